### rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared constants and types of the slip frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int FRAME_DEPTH = 2048;
   localparam int CNT_W       = $clog2(FRAME_DEPTH);
   localparam int POS_W       = 11;
   localparam int IDX_W       = 2;
   localparam int DATA_W      = 8;

   localparam logic [7:0] CODE_END     = 8'o300;
   localparam logic [7:0] CODE_ESC     = 8'o333;
   localparam logic [7:0] CODE_ESC_END = 8'o334;
   localparam logic [7:0] CODE_ESC_ESC = 8'o335;

   localparam logic [IDX_W-1:0] REG_PASSTHROUGH = 2'd0;
   localparam logic [IDX_W-1:0] REG_MATCH_EN    = 2'd1;
   localparam logic [IDX_W-1:0] REG_MATCH_BYTE  = 2'd2;

   typedef enum logic [1:0] {
      KIND_TEXT     = 2'd0,
      KIND_DATA     = 2'd1,
      KIND_END      = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      FRAME_OUT     = 2'd0,
      FRAME_IN      = 2'd1,
      FRAME_SPOILED = 2'd2
   } frame_type;

   typedef struct packed {
      logic       passthrough_enable;
      logic       match_enable;
      logic [7:0] match_byte;
   } cfg_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       byte_value;
      logic [POS_W-1:0] byte_position;
      logic             frame_ok;
      logic             response_match;
   } result_type;

endpackage

### rtl/core/sfr_decoder.sv
// ----------------------------------------------------------------------------
// sfr_decoder
// slip deframing state and per-byte result logic
// ----------------------------------------------------------------------------
module sfr_decoder
   import sfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step_en,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type res
);

   logic             escape_ff, escape_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   frame_type        frame_ff, frame_in;
   logic [7:0]       second_ff, second_in;
   logic [7:0]       data;
   logic             ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
         fill_ff   <= '0;
         frame_ff  <= FRAME_OUT;
         second_ff <= '0;
      end else if (step_en) begin
         escape_ff <= escape_in;
         fill_ff   <= fill_in;
         frame_ff  <= frame_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      escape_in = escape_ff;
      fill_in   = fill_ff;
      frame_in  = frame_ff;
      second_in = second_ff;
      res_valid = 1'b0;
      res       = '0;
      data      = rx_byte;
      ok        = (frame_ff != FRAME_SPOILED);
      if (cfg.passthrough_enable && frame_ff == FRAME_OUT && rx_byte != CODE_END) begin
         res_valid      = 1'b1;
         res.kind       = KIND_TEXT;
         res.byte_value = rx_byte;
      end else if (rx_byte == CODE_ESC) begin
         escape_in = 1'b1;
      end else if (rx_byte == CODE_END) begin
         if (fill_ff != '0) begin
            res_valid          = 1'b1;
            res.kind           = KIND_END;
            res.byte_position  = POS_W'(fill_ff);
            res.frame_ok       = ok;
            res.response_match = cfg.match_enable && ok && (second_ff == cfg.match_byte);
            escape_in          = 1'b0;
            fill_in            = '0;
            frame_in           = FRAME_OUT;
         end else begin
            frame_in = (frame_ff == FRAME_OUT) ? FRAME_IN : FRAME_OUT;
         end
      end else begin
         if (escape_ff) begin
            escape_in = 1'b0;
            if (rx_byte == CODE_ESC_END) begin
               data = CODE_END;
            end else if (rx_byte == CODE_ESC_ESC) begin
               data = CODE_ESC;
            end
         end
         if (fill_ff == CNT_W'(1)) begin
            second_in = data;
         end
         res_valid         = 1'b1;
         res.byte_value    = data;
         res.byte_position = POS_W'(fill_ff);
         if (fill_ff == CNT_W'(FRAME_DEPTH - 1)) begin
            res.kind = KIND_OVERFLOW;
            fill_in  = '0;
            frame_in = FRAME_SPOILED;
         end else begin
            res.kind = KIND_DATA;
            fill_in  = fill_ff + CNT_W'(1);
         end
      end
   end

endmodule

### rtl/core/sfr_out_queue.sv
// ----------------------------------------------------------------------------
// sfr_out_queue
// two-entry result buffer between decoder and result channel
// ----------------------------------------------------------------------------
module sfr_out_queue
   import sfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   result_type  entry_ff [2];
   logic        head_ff, head_in;
   logic        tail_ff, tail_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign space     = (count_ff != 2'd2) || pop;
   assign rsp_data  = entry_ff[head_ff];

   always_comb begin
      head_in  = pop ? ~head_ff : head_ff;
      tail_in  = push ? ~tail_ff : tail_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      push |-> space)
      else $error("result pushed into full buffer");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1 && pop && !push) |=> !rsp_valid)
      else $error("result buffer not empty after last transfer");
`endif

endmodule

### rtl/core/slip_frame_receiver.sv
// ----------------------------------------------------------------------------
// slip_frame_receiver
// slip deframer: one received byte per transfer, zero or one result each
// path: input register, decode once buffer has space, buffer offers result
// throughput: one byte per cycle while buffer has space; each is a decoder step
// a two-entry result buffer keeps input transfers going while a result waits
// reset: synchronous, active high; clears frame state, buffers and registers
// ----------------------------------------------------------------------------
module slip_frame_receiver
   import sfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_byte_value,
   output logic [POS_W-1:0]  rsp_byte_position,
   output logic              rsp_frame_ok,
   output logic              rsp_response_match,
   input  logic              csr_write_enable,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0] csr_write_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       space;
   logic       res_valid;
   result_type res;
   result_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.passthrough_enable <= 1'b1;
         cfg_ff.match_enable       <= 1'b0;
         cfg_ff.match_byte         <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_PASSTHROUGH: cfg_ff.passthrough_enable <= csr_write_data[0];
            REG_MATCH_EN:    cfg_ff.match_enable       <= csr_write_data[0];
            REG_MATCH_BYTE:  cfg_ff.match_byte         <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   assign advance   = in_valid_ff && space;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sfr_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step_en   (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   sfr_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && res_valid),
      .push_data (res),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind           = rsp_data.kind;
   assign rsp_byte_value     = rsp_data.byte_value;
   assign rsp_byte_position  = rsp_data.byte_position;
   assign rsp_frame_ok       = rsp_data.frame_ok;
   assign rsp_response_match = rsp_data.response_match;

`ifndef ASSERT_OFF
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("stalled input byte lost");
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input not ready while stage empty");
   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid && res.kind == KIND_END) |-> (res.byte_value == 8'd0))
      else $error("frame end carries a byte value");
   a_text_fields: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid && res.kind == KIND_TEXT)
         |-> (res.byte_position == '0 && !res.frame_ok && !res.response_match))
      else $error("text byte carries frame fields");
`endif

endmodule
